FILE: rtl/pvbu_pkg.sv
// ----------------------------------------------------------------------------
// pvbu_pkg
// Types, constants and the arctangent table shared by the phase vocoder
// bin update core.
// ----------------------------------------------------------------------------
package pvbu_pkg;

	localparam int FFT_POINTS_DEF   = 2048;
	localparam int SRC_HOP_DEF      = 512;
	localparam int BIN_W            = 10;
	localparam int HOP_W            = 11;
	localparam logic [HOP_W-1:0] HOP_RST = 11'd512;
	localparam int CORDIC_STEPS     = 28;
	localparam int MAG_W            = 32;
	localparam int VX_W             = 60;
	localparam int RX_W             = 34;
	localparam logic signed [RX_W-1:0] INV_GAIN_Q30 = 34'sd652032874;
	localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

	typedef struct packed {
		logic signed [31:0] spec_real;
		logic signed [31:0] spec_imag;
		logic [BIN_W-1:0]   bin_number;
	} spec_t;

	typedef struct packed {
		logic signed [31:0] out_real;
		logic signed [31:0] out_imag;
		logic [BIN_W-1:0]   out_bin;
	} res_t;

	// front to back: measured phase and magnitude of one bin
	typedef struct packed {
		logic [31:0]      phase;
		logic [MAG_W-1:0] mag;
		logic [BIN_W-1:0] bin;
	} meas_t;

	function automatic logic [31:0] atan_turn(input int unsigned i);
		logic [31:0] r;
		case (i)
			0:  r = 32'h20000000;
			1:  r = 32'h12E4051E;
			2:  r = 32'h09FB385B;
			3:  r = 32'h051111D4;
			4:  r = 32'h028B0D43;
			5:  r = 32'h0145D7E1;
			6:  r = 32'h00A2F61E;
			7:  r = 32'h00517C55;
			8:  r = 32'h0028BE53;
			9:  r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2FA;
			15: r = 32'h0000517D;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A30;
			19: r = 32'h00000518;
			20: r = 32'h0000028C;
			21: r = 32'h00000146;
			22: r = 32'h000000A3;
			23: r = 32'h00000051;
			24: r = 32'h00000029;
			25: r = 32'h00000014;
			26: r = 32'h0000000A;
			27: r = 32'h00000005;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/pvbu_front.sv
// ----------------------------------------------------------------------------
// pvbu_front
// Accepts bins and measures them: exact integer square root of the power
// and CORDIC vectoring angle in 32-bit turns, one stage per step.
// ----------------------------------------------------------------------------
module pvbu_front import pvbu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  go,
	input  logic  spec_valid,
	output logic  spec_ready,
	input  spec_t spec,
	output logic  m_valid,
	output meas_t m,
	input  logic  m_full
);

	localparam int NST     = 34;
	localparam int COR_END = CORDIC_STEPS + 1;

	logic en_f;

	logic                   vld_q  [1:NST];
	logic [BIN_W-1:0]       bin_q  [1:NST];
	logic                   zero_q [1:NST];
	logic signed [VX_W-1:0] x_q    [1:NST];
	logic signed [VX_W-1:0] y_q    [1:NST];
	logic [31:0]            ang_q  [1:NST];
	logic [63:0]            n_q    [1:NST];
	logic [63:0]            root_q [1:NST];
	logic signed [63:0]     sqr_q;
	logic signed [63:0]     sqi_q;

	assign en_f       = !(vld_q[NST] && m_full);
	assign spec_ready = en_f && go;

	// stage 1: squares, scaled vector, half-turn pre-rotation
	logic signed [63:0]     sqr_d, sqi_d;
	logic signed [VX_W-1:0] x0, y0;
	always_comb begin
		sqr_d = spec.spec_real * spec.spec_real;
		sqi_d = spec.spec_imag * spec.spec_imag;
		x0 = VX_W'(spec.spec_real) <<< 24;
		y0 = VX_W'(spec.spec_imag) <<< 24;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[1] <= 1'b0;
		end else if (en_f) begin
			vld_q[1] <= spec_valid && spec_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (en_f) begin
			sqr_q     <= sqr_d;
			sqi_q     <= sqi_d;
			bin_q[1]  <= spec.bin_number;
			zero_q[1] <= (spec.spec_real == 32'sd0) && (spec.spec_imag == 32'sd0);
			n_q[1]    <= 64'd0;
			root_q[1] <= 64'd0;
			if (spec.spec_real[31]) begin
				x_q[1]   <= -x0;
				y_q[1]   <= -y0;
				ang_q[1] <= HALF_TURN;
			end else begin
				x_q[1]   <= x0;
				y_q[1]   <= y0;
				ang_q[1] <= 32'd0;
			end
		end
	end

	for (genvar s = 2; s <= NST; s++) begin : g_st
		logic signed [VX_W-1:0] xn, yn;
		logic [31:0]            an;
		logic [63:0]            nn, rn, bt;
		always_comb begin
			xn = x_q[s-1];
			yn = y_q[s-1];
			an = ang_q[s-1];
			nn = n_q[s-1];
			rn = root_q[s-1];
			bt = 64'd0;
			if (s <= COR_END) begin
				if (!y_q[s-1][VX_W-1]) begin
					xn = x_q[s-1] + (y_q[s-1] >>> (s - 2));
					yn = y_q[s-1] - (x_q[s-1] >>> (s - 2));
					an = ang_q[s-1] + atan_turn(s - 2);
				end else begin
					xn = x_q[s-1] - (y_q[s-1] >>> (s - 2));
					yn = y_q[s-1] + (x_q[s-1] >>> (s - 2));
					an = ang_q[s-1] - atan_turn(s - 2);
				end
			end
			if (s == 2) begin
				nn = 64'(sqr_q) + 64'(sqi_q);
				rn = 64'd0;
			end else begin
				bt = 64'd1 << (62 - 2 * (s - 3));
				if (n_q[s-1] >= root_q[s-1] + bt) begin
					nn = n_q[s-1] - (root_q[s-1] + bt);
					rn = (root_q[s-1] >> 1) + bt;
				end else begin
					rn = root_q[s-1] >> 1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[s] <= 1'b0;
			end else if (en_f) begin
				vld_q[s] <= vld_q[s-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en_f) begin
				bin_q[s]  <= bin_q[s-1];
				zero_q[s] <= zero_q[s-1];
				x_q[s]    <= xn;
				y_q[s]    <= yn;
				ang_q[s]  <= an;
				n_q[s]    <= nn;
				root_q[s] <= rn;
			end
		end
	end

	assign m_valid = vld_q[NST];
	always_comb begin
		m.phase = zero_q[NST] ? 32'd0 : ang_q[NST];
		m.mag   = root_q[NST][MAG_W-1:0];
		m.bin   = bin_q[NST];
	end

endmodule

FILE: rtl/pvbu_queue.sv
// ----------------------------------------------------------------------------
// pvbu_queue
// Four-entry queue between the measuring front and the updating back.
// ----------------------------------------------------------------------------
module pvbu_queue import pvbu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  meas_t din,
	output logic  full,
	input  logic  pop,
	output logic  nonempty,
	output meas_t head
);

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	meas_t         buf_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;

	assign full     = (cnt_q == (AW+1)'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			buf_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop && nonempty) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push && !full, pop && nonempty})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/pvbu_back.sv
// ----------------------------------------------------------------------------
// pvbu_back
// Per-bin phase state update with write forwarding, CORDIC rotation to the
// accumulated phase, magnitude scaling and saturation. Clears both stores
// after reset.
// ----------------------------------------------------------------------------
module pvbu_back import pvbu_pkg::*; #(
	parameter int FFT_POINTS = FFT_POINTS_DEF,
	parameter int SRC_HOP    = SRC_HOP_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [HOP_W-1:0] hop,
	input  logic             q_nonempty,
	input  meas_t            q_head,
	output logic             q_pop,
	output logic             init_done,
	output logic             res_valid,
	input  logic             res_ready,
	output res_t             res
);

	localparam int LG_FFT = $clog2(FFT_POINTS);
	localparam int LG_AH  = $clog2(SRC_HOP);
	localparam int NBIN   = 1 << BIN_W;
	localparam int PRD_W  = MAG_W + 1 + RX_W;

	logic en_b;
	assign en_b = !res_valid || res_ready;

	// clearing pass
	logic [BIN_W:0] clr_q;
	assign init_done = clr_q[BIN_W];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!init_done) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign q_pop = en_b && q_nonempty && init_done;

	// state stores
	logic [31:0] prev_mem [NBIN];
	logic [31:0] acc_mem  [NBIN];

	logic             wr_en;
	logic [BIN_W-1:0] wr_addr;
	logic [31:0]      wr_prev, wr_acc;

	logic             v_s1;
	meas_t            meas_s1;
	logic [31:0]      prev_rd_s1, acc_rd_s1, byp_prev_s1, byp_acc_s1;
	logic             byp_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			prev_mem[wr_addr] <= wr_prev;
			acc_mem[wr_addr]  <= wr_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			prev_rd_s1  <= prev_mem[q_head.bin];
			acc_rd_s1   <= acc_mem[q_head.bin];
			byp_s1      <= wr_en && (wr_addr == q_head.bin);
			byp_prev_s1 <= wr_prev;
			byp_acc_s1  <= wr_acc;
			meas_s1     <= q_head;
		end
	end

	// phase update
	logic [31:0]        prev_c, acc_c, expct, dev, adv_lin, adv_dev, acc_new;
	logic signed [44:0] dprod, dadj;
	always_comb begin
		prev_c  = byp_s1 ? byp_prev_s1 : prev_rd_s1;
		acc_c   = byp_s1 ? byp_acc_s1 : acc_rd_s1;
		expct   = 32'((64'(meas_s1.bin) * 64'(SRC_HOP)) << (32 - LG_FFT));
		dev     = meas_s1.phase - prev_c - expct;
		adv_lin = 32'((64'(meas_s1.bin) * 64'(hop)) << (32 - LG_FFT));
		dprod   = 45'($signed(dev)) * $signed({1'b0, hop});
		dadj    = dprod[44] ? dprod + 45'(SRC_HOP - 1) : dprod;
		adv_dev = 32'(dadj >>> LG_AH);
		acc_new = acc_c + adv_lin + adv_dev;
	end

	always_comb begin
		if (init_done) begin
			wr_en   = v_s1 && en_b;
			wr_addr = meas_s1.bin;
			wr_prev = meas_s1.phase;
			wr_acc  = acc_new;
		end else begin
			wr_en   = 1'b1;
			wr_addr = clr_q[BIN_W-1:0];
			wr_prev = 32'd0;
			wr_acc  = 32'd0;
		end
	end

	// stage 2: accumulated phase
	logic             v_s2;
	logic [31:0]      ang_s2;
	logic [MAG_W-1:0] mag_s2;
	logic [BIN_W-1:0] bin_s2;
	always_ff @(posedge clk) begin
		if (en_b) begin
			ang_s2 <= acc_new;
			mag_s2 <= meas_s1.mag;
			bin_s2 <= meas_s1.bin;
		end
	end

	// rotation: index 0 prepared, index i+1 after step i
	logic                   rv_q   [0:CORDIC_STEPS];
	logic signed [RX_W-1:0] rx_q   [0:CORDIC_STEPS];
	logic signed [RX_W-1:0] ry_q   [0:CORDIC_STEPS];
	logic signed [RX_W-1:0] rz_q   [0:CORDIC_STEPS];
	logic                   rf_q   [0:CORDIC_STEPS];
	logic [MAG_W-1:0]       rmag_q [0:CORDIC_STEPS];
	logic [BIN_W-1:0]       rbin_q [0:CORDIC_STEPS];

	logic        flip;
	logic [31:0] aturn;
	always_comb begin
		flip  = ((ang_s2 + QUARTER_TURN) & HALF_TURN) != 32'd0;
		aturn = flip ? ang_s2 + HALF_TURN : ang_s2;
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			rx_q[0]   <= INV_GAIN_Q30;
			ry_q[0]   <= '0;
			rz_q[0]   <= RX_W'($signed(aturn));
			rf_q[0]   <= flip;
			rmag_q[0] <= mag_s2;
			rbin_q[0] <= bin_s2;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		logic signed [RX_W-1:0] xn, yn, zn;
		always_comb begin
			if (!rz_q[i][RX_W-1]) begin
				xn = rx_q[i] - (ry_q[i] >>> i);
				yn = ry_q[i] + (rx_q[i] >>> i);
				zn = rz_q[i] - RX_W'(atan_turn(i));
			end else begin
				xn = rx_q[i] + (ry_q[i] >>> i);
				yn = ry_q[i] - (rx_q[i] >>> i);
				zn = rz_q[i] + RX_W'(atan_turn(i));
			end
		end
		always_ff @(posedge clk) begin
			if (en_b) begin
				rx_q[i+1]   <= xn;
				ry_q[i+1]   <= yn;
				rz_q[i+1]   <= zn;
				rf_q[i+1]   <= rf_q[i];
				rmag_q[i+1] <= rmag_q[i];
				rbin_q[i+1] <= rbin_q[i];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rv_q[i+1] <= 1'b0;
			end else if (en_b) begin
				rv_q[i+1] <= rv_q[i];
			end
		end
	end

	// products
	logic                    v_pr;
	logic signed [PRD_W-1:0] pre_q, pim_q;
	logic [BIN_W-1:0]        pbin_q;
	logic signed [RX_W-1:0]  cs, sn;
	logic signed [MAG_W:0]   mg;
	always_comb begin
		cs = rf_q[CORDIC_STEPS] ? -rx_q[CORDIC_STEPS] : rx_q[CORDIC_STEPS];
		sn = rf_q[CORDIC_STEPS] ? -ry_q[CORDIC_STEPS] : ry_q[CORDIC_STEPS];
		mg = $signed({1'b0, rmag_q[CORDIC_STEPS]});
	end
	always_ff @(posedge clk) begin
		if (en_b) begin
			pre_q  <= PRD_W'(mg) * PRD_W'(cs);
			pim_q  <= PRD_W'(mg) * PRD_W'(sn);
			pbin_q <= rbin_q[CORDIC_STEPS];
		end
	end

	function automatic logic signed [31:0] round_sat(input logic signed [PRD_W-1:0] p);
		logic signed [PRD_W-1:0] r;
		r = (p + PRD_W'(64'sd536870912)) >>> 30;
		if (r > PRD_W'(64'sd2147483647)) begin
			return 32'sh7FFF_FFFF;
		end else if (r < -PRD_W'(64'sd2147483648)) begin
			return 32'sh8000_0000;
		end
		return r[31:0];
	endfunction

	logic vout_q;
	always_ff @(posedge clk) begin
		if (en_b) begin
			res.out_real <= round_sat(pre_q);
			res.out_imag <= round_sat(pim_q);
			res.out_bin  <= pbin_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			rv_q[0] <= 1'b0;
			v_pr    <= 1'b0;
			vout_q  <= 1'b0;
		end else if (en_b) begin
			v_s1    <= q_pop;
			v_s2    <= v_s1;
			rv_q[0] <= v_s2;
			v_pr    <= rv_q[CORDIC_STEPS];
			vout_q  <= v_pr;
		end
	end

	assign res_valid = vout_q;

endmodule

FILE: rtl/phase_vocoder_bin_update_core.sv
// ----------------------------------------------------------------------------
// phase_vocoder_bin_update_core
// Phase vocoder per-bin phase propagation.
// ----------------------------------------------------------------------------
// Input channel spec_valid/spec_ready/spec carries one analysis bin (Q15.16
// real and imaginary parts, bin index). Output channel res_valid/res_ready/res
// returns one resynthesized bin per input item, in order.
// cfg_we/cfg_data write the synthesis hop (reset 512); write only when idle.
// Throughput: one item per cycle, sustained while res_ready stays high.
// Pipeline: 34 measuring stages (square root and CORDIC vectoring); queue;
// state read; phase update; 29 rotation stages; product; output.
// The per-bin stores are updated by a read-modify-write with forwarding, so
// repeated bins back to back are handled at full rate.
// After reset a clearing pass zeroes all 1024 entries of both per-bin stores;
// spec_ready stays low until it ends.
// When res_valid is high and res_ready is low the back pipeline holds; the
// 4-entry queue absorbs the measuring pipeline until it also stalls and spec_ready drops.
// ----------------------------------------------------------------------------
module phase_vocoder_bin_update_core import pvbu_pkg::*; #(
	parameter int FFT_POINTS = FFT_POINTS_DEF,
	parameter int SRC_HOP    = SRC_HOP_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             spec_valid,
	output logic             spec_ready,
	input  spec_t            spec,
	output logic             res_valid,
	input  logic             res_ready,
	output res_t             res,
	input  logic             cfg_we,
	input  logic [HOP_W-1:0] cfg_data
);

	logic [HOP_W-1:0] hop_q;
	logic             go, m_valid, m_full, q_pop, q_nonempty;
	meas_t            m, q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hop_q <= HOP_RST;
		end else if (cfg_we) begin
			hop_q <= cfg_data;
		end
	end

	pvbu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.spec_valid (spec_valid),
		.spec_ready (spec_ready),
		.spec       (spec),
		.m_valid    (m_valid),
		.m          (m),
		.m_full     (m_full)
	);

	pvbu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (m_valid),
		.din      (m),
		.full     (m_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.head     (q_head)
	);

	pvbu_back #(
		.FFT_POINTS (FFT_POINTS),
		.SRC_HOP    (SRC_HOP)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.hop        (hop_q),
		.q_nonempty (q_nonempty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.init_done  (go),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

endmodule

FILE: rtl/pvbu_checker.sv
// ----------------------------------------------------------------------------
// pvbu_checker
// Port-level checks for the bin update core, attached by bind.
// ----------------------------------------------------------------------------
module pvbu_checker import pvbu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic spec_valid,
	input logic spec_ready,
	input logic res_valid,
	input logic res_ready,
	input res_t res
);

	localparam int MAX_OUT = 80;

	logic [7:0] out_q;
	logic       in_acc, out_acc;
	assign in_acc  = spec_valid && spec_ready;
	assign out_acc = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else begin
			case ({in_acc, out_acc})
				2'b10:   out_q <= out_q + 1'b1;
				2'b01:   out_q <= out_q - 1'b1;
				default: out_q <= out_q;
			endcase
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> out_q != 8'd0)
		else $error("result without pending item");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_q <= 8'(MAX_OUT))
		else $error("too many items in flight");

endmodule

bind phase_vocoder_bin_update_core pvbu_checker u_pvbu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.spec_valid (spec_valid),
	.spec_ready (spec_ready),
	.res_valid  (res_valid),
	.res_ready  (res_ready),
	.res        (res)
);
